// ----- rtl/core/cbi_pkg.sv -----
// Shared constants and types for the convolutional byte interleaver.
// No dependencies; used by cbi_addr_gen, the top level and the testbench.
package cbi_pkg;

  localparam int unsigned BranchCountDef = 12;
  localparam int unsigned CellDepthDef   = 17;

  // Per-transfer control from the address generator to the datapath.
  typedef struct packed {
    logic pass;    // branch zero: byte goes straight through
    logic filled;  // branch has wrapped once, store entry holds real data
  } cbi_req_t;

endpackage

// ----- rtl/core/cbi_store.sv -----
// Delay store: single-port synchronous byte memory, read-first, registered read.
// Depends on nothing but its parameters.
module cbi_store #(
  parameter int unsigned Depth = 1122,
  parameter int unsigned AddrW = 11
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // Old contents come out, new byte goes in, same slot.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem_q[addr_i];
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cbi_addr_gen.sv -----
// Branch selector and per-branch circular pointers for the delay store.
// Depends on cbi_pkg.
module cbi_addr_gen #(
  parameter int unsigned BranchCount = 12,
  parameter int unsigned CellDepth   = 17,
  parameter int unsigned AddrW       = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  output logic [AddrW-1:0]  addr_o,
  output cbi_pkg::cbi_req_t req_o
);
  import cbi_pkg::*;

  localparam int unsigned MaxLen = CellDepth * (BranchCount - 1);
  localparam int unsigned PtrW   = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned LenW   = $clog2(MaxLen + 1);
  localparam int unsigned BrW    = $clog2(BranchCount);

  logic [BrW-1:0]   branch_q, branch_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [PtrW-1:0]  ptr_q [BranchCount];
  logic [BranchCount-1:0] filled_q;

  logic [PtrW-1:0] ptr_cur;
  logic [LenW-1:0] ptr_inc;
  logic            wrap;
  logic            last;

  assign ptr_cur = ptr_q[branch_q];
  assign ptr_inc = LenW'(ptr_cur) + LenW'(1);
  assign wrap    = (ptr_inc == len_q);
  assign last    = (branch_q == BrW'(BranchCount - 1));

  assign addr_o       = base_q + AddrW'(ptr_cur);
  assign req_o.pass   = (branch_q == '0);
  assign req_o.filled = filled_q[branch_q];

  // Base and length of the next branch follow by one add each, or go to zero after the last branch.
  always_comb begin
    if (last) begin
      branch_d = '0;
      base_d   = '0;
      len_d    = '0;
    end else begin
      branch_d = branch_q + BrW'(1);
      base_d   = base_q + AddrW'(len_q);
      len_d    = len_q + LenW'(CellDepth);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      branch_q <= '0;
      base_q   <= '0;
      len_q    <= '0;
      filled_q <= '0;
      for (int i = 0; i < int'(BranchCount); i++) begin
        ptr_q[i] <= '0;
      end
    end else if (step_i) begin
      branch_q <= branch_d;
      base_q   <= base_d;
      len_q    <= len_d;
      if (!req_o.pass) begin
        if (wrap) begin
          ptr_q[branch_q]    <= '0;
          filled_q[branch_q] <= 1'b1;
        end else begin
          ptr_q[branch_q] <= ptr_inc[PtrW-1:0];
        end
      end
    end
  end

endmodule

// ----- rtl/core/convolutional_byte_interleaver.sv -----
// Top level of the convolutional byte interleaver (Forney type).
// Depends on cbi_pkg, cbi_addr_gen and cbi_store.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-----------------
//   in      | in  | in_valid_i / in_stall_o | in_byte_i  [7:0]
//   out     | out | out_valid_o / out_stall_i | out_byte_o [7:0]
//
// One byte per clock sustained unless the output stalls: each transfer costs
// one read-first access of the single-port delay store, and the next branch's
// address is ready from registers. Bytes pass the store read, then the output register.
// After reset no clearing pass is run: a per-branch filled flag makes a
// branch output zeros until its pointer has wrapped once.
// An output stall holds the output register; a second byte may still be
// taken into the store stage, after which the input stalls.
module convolutional_byte_interleaver #(
  parameter int unsigned BranchCount = cbi_pkg::BranchCountDef,
  parameter int unsigned CellDepth   = cbi_pkg::CellDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o
);
  import cbi_pkg::*;

  localparam int unsigned StoreSize = CellDepth * BranchCount * (BranchCount - 1) / 2;
  localparam int unsigned AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;

  logic             in_xfer;
  logic [AddrW-1:0] mem_addr;
  cbi_req_t         req;
  logic [7:0]       rd_data;

  // Store stage: waits for the registered memory read.
  logic       s1_valid_q;
  logic       s1_pass_q;
  logic       s1_filled_q;
  logic [7:0] s1_byte_q;
  logic       s1_adv;

  // Output register.
  logic       out_valid_q;
  logic [7:0] out_byte_q, out_byte_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  cbi_addr_gen #(
    .BranchCount(BranchCount),
    .CellDepth  (CellDepth),
    .AddrW      (AddrW)
  ) u_addr_gen (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(in_xfer),
    .addr_o(mem_addr),
    .req_o (req)
  );

  // Read enable only on a transfer, so rd_data holds while the stage waits.
  cbi_store #(
    .Depth(StoreSize),
    .AddrW(AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (in_xfer && !req.pass),
    .addr_i (mem_addr),
    .wdata_i(in_byte_i),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pass_q   <= req.pass;
      s1_filled_q <= req.filled;
      s1_byte_q   <= in_byte_i;
    end
  end

  // Branch zero bypasses; an unwrapped branch outputs zero in place of the store data.
  always_comb begin
    if (s1_pass_q) begin
      out_byte_d = s1_byte_q;
    end else if (s1_filled_q) begin
      out_byte_d = rd_data;
    end else begin
      out_byte_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_byte_q <= out_byte_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  // Store accesses stay inside the array.
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !req.pass |-> 32'(mem_addr) < StoreSize)
    else $error("delay store address out of range");

  // A waiting store stage keeps its read data.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(rd_data))
    else $error("store stage data lost while waiting");

  // Both stages full and output stalled: input must stall.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input taken with pipeline full");

endmodule

// ----- bench/convolutional_byte_interleaver_tb.sv -----
// Self-checking testbench for the convolutional byte interleaver.
// Depends on cbi_pkg and convolutional_byte_interleaver; an in-bench predictor
// models the branch delays, and each output transfer is checked against it.
module convolutional_byte_interleaver_tb;

  localparam int unsigned LaneCount   = cbi_pkg::BranchCountDef;
  localparam int unsigned CellDepth   = cbi_pkg::CellDepthDef;
  localparam int unsigned StoreBytes  = CellDepth * LaneCount * (LaneCount - 1) / 2;
  localparam int unsigned IdlePct     = 10;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StuckLimit  = 3000;
  localparam int unsigned SettleCycles = 20;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;

  // Predictor state: one circular delay line per branch above zero, packed in one store.
  logic [7:0]  delay_line [StoreBytes];
  int unsigned lane_ptr [LaneCount];
  int unsigned lane_sel;

  logic [7:0]  expected_bytes [$];
  int unsigned fail_count   = 0;
  int unsigned stuck_cycles = 0;
  bit          quiet        = 1'b0;   // no idling on either side
  int unsigned holdoff_reqs = 0;      // raised by the test sequence
  int unsigned holdoff_done = 0;      // taken up by the receiver process
  int unsigned holdoff_left = 0;

  convolutional_byte_interleaver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o)
  );

  always #1 clk_i = ~clk_i;

  // Branch 0 passes through; branch b returns the byte it took b*CellDepth
  // visits ago (zero until its line has wrapped once).
  function automatic logic [7:0] interleave_next(input logic [7:0] byte_in);
    int unsigned base;
    int unsigned slot;
    logic [7:0]  byte_out;
    if (lane_sel == 0) begin
      byte_out = byte_in;
    end else begin
      base = CellDepth * lane_sel * (lane_sel - 1) / 2;
      slot = base + lane_ptr[lane_sel];
      byte_out = delay_line[slot];
      delay_line[slot] = byte_in;
      if (lane_ptr[lane_sel] + 1 == CellDepth * lane_sel) begin
        lane_ptr[lane_sel] = 0;
      end else begin
        lane_ptr[lane_sel] = lane_ptr[lane_sel] + 1;
      end
    end
    lane_sel = (lane_sel == LaneCount - 1) ? 0 : lane_sel + 1;
    return byte_out;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Offer one byte, hold it until the transfer, then record its prediction.
  task automatic send_byte(input logic [7:0] value);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= value;
    do @(posedge clk_i); while (in_stall_o);
    expected_bytes.push_back(interleave_next(value));
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) send_byte(8'($urandom_range(255)));
  endtask

  // Extremes and walking bits over two full rounds of the branch selector,
  // so each branch sees its cleared start-up output and branch 0 its bypass.
  task automatic test_directed_bytes();
    logic [7:0] pattern [24];
    pattern = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h02, 8'h40,
                8'h04, 8'h20, 8'h08, 8'h10, 8'hFE, 8'h7F, 8'hFD, 8'hBF,
                8'hFB, 8'hDF, 8'hF7, 8'hEF, 8'h0F, 8'hF0, 8'h33, 8'hCC};
    foreach (pattern[k]) send_byte(pattern[k]);
  endtask

  task automatic test_quiet_stream();
    quiet = 1'b1;
    send_random(300);
    quiet = 1'b0;
  endtask

  // Long random run; together with the rest it wraps the shallower branches.
  task automatic test_random_stream();
    send_random(626);
  endtask

  // Receiver stops for a long stretch while bytes keep coming: the block
  // fills and must stall its input without losing or repeating a transfer.
  task automatic test_receiver_holdoff();
    holdoff_reqs = holdoff_reqs + 1;
    send_random(400);
  endtask

  // Sender goes quiet until every result is out, then resumes.
  task automatic test_sender_pause();
    send_random(200);
    release_input();
    wait_drained();
    send_random(200);
  endtask

  // Receiver side: random stalls, or a counted hold-off when requested.
  always @(negedge clk_i) begin
    if (holdoff_done != holdoff_reqs) begin
      holdoff_done = holdoff_reqs;
      holdoff_left = HoldCycles;
    end
    if (holdoff_left != 0) begin
      out_stall_i <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < IdlePct);
    end
  end

  // Output checker: every output transfer against the oldest prediction.
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected out_byte %02h", out_byte_o));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want) begin
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, want));
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("watchdog: no transfer for %0d cycles", StuckLimit);
      $display("status: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    for (int unsigned k = 0; k < StoreBytes; k++) delay_line[k] = 8'h00;
    for (int unsigned k = 0; k < LaneCount; k++) lane_ptr[k] = 0;
    lane_sel = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_bytes();
    test_quiet_stream();
    test_random_stream();
    test_receiver_holdoff();
    test_sender_pause();

    release_input();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- convolutional_byte_interleaver.f -----
rtl/core/cbi_pkg.sv
rtl/core/cbi_store.sv
rtl/core/cbi_addr_gen.sv
rtl/core/convolutional_byte_interleaver.sv
bench/convolutional_byte_interleaver_tb.sv
